// File: rtl/core/cls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cls_pkg: shared types and constants of the comment and literal scanner
// Character codes, scanner state codes and the word layouts that the step
// logic and the top level exchange.
// ----------------------------------------------------------------------------
package cls_pkg;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam int unsigned ST_W = 4;
  localparam logic [ST_W-1:0] ST_CODE  = 4'd0;
  localparam logic [ST_W-1:0] ST_SLASH = 4'd1;
  localparam logic [ST_W-1:0] ST_BLOCK = 4'd2;
  localparam logic [ST_W-1:0] ST_LINE  = 4'd3;
  localparam logic [ST_W-1:0] ST_STAR  = 4'd4;
  localparam logic [ST_W-1:0] ST_DQ    = 4'd5;
  localparam logic [ST_W-1:0] ST_SQ    = 4'd6;
  localparam logic [ST_W-1:0] ST_DESC  = 4'd7;
  localparam logic [ST_W-1:0] ST_SESC  = 4'd8;

  typedef struct packed {
    logic comment;
    logic str;
    logic chr;
  } flags_t;

  // One result word, without its last marker.
  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
    flags_t     tags;
    logic       err;
  } res_t;

  // Everything one input item produces.
  typedef struct packed {
    logic [ST_W-1:0] state;
    flags_t          flags;
    logic [1:0]      cnt;
    res_t            r0;
    res_t            r1;
  } step_t;

endpackage : cls_pkg
`default_nettype wire

// File: rtl/core/c_comment_literal_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c_comment_literal_scanner: C/C++ comment and literal tagging scanner
// Tags each non-NUL source byte as comment, string literal, character
// constant or code and passes it on, with an end word per end marker.
// ----------------------------------------------------------------------------
// Usage. The input channel (in_valid/in_ready) carries one word per cycle
// while in_ready is high: a source byte, or an end-of-input marker when
// in_command is set. The result channel (out_valid/out_ready) carries
// tagged bytes and end words; out_last marks the final result word caused
// by one input word. A slash in code is held back until the next byte
// decides whether it opens a comment, so one input word gives zero, one or
// two result words. NUL bytes give no word of their own but still move the
// scanner. The step logic works directly on the accepted word and writes
// its results into a two-entry result queue, whose head drives the outputs
// from registers. Throughput is one input word per cycle while the receiver
// keeps up; an input that gives two words holds the output until both are
// taken, so the output port (one word per cycle) sets the rate.
// When the receiver stalls, the queue absorbs up to two input words and then
// in_ready drops; nothing is lost or repeated.
// Synchronous active-low reset returns the scanner to code with all tags
// clear and empties the queue. An end marker does the same to the scanner.
// ----------------------------------------------------------------------------
module c_comment_literal_scanner (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_command,
  input  wire logic [7:0] in_char_in,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char_out,
  output logic            out_is_end,
  output logic            out_in_comment,
  output logic            out_in_string,
  output logic            out_in_char_const,
  output logic            out_open_comment_error,
  output logic            out_last
);
  import cls_pkg::*;

  // One queue entry holds all results of one input word.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  logic [ST_W-1:0] state_r, state_nxt;
  flags_t          flags_r, flags_nxt;
  step_t           step;

  entry_t     entry_r [2];
  logic       wr_ptr_r, rd_ptr_r, sub_r;
  logic [1:0] count_r, count_nxt;

  logic   in_fire, out_fire, push, pop;
  entry_t head;
  res_t   head_res;

  cls_step u_step (
    .scan_state (state_r),
    .flags      (flags_r),
    .command    (in_command),
    .char_in    (in_char_in),
    .step       (step)
  );

  // The head entry leaves once its last word is taken.
  assign head      = entry_r[rd_ptr_r];
  assign head_res  = sub_r ? head.r1 : head.r0;
  assign out_valid = (count_r != 2'd0);
  assign out_last  = sub_r | ~head.two;
  assign out_fire  = out_valid & out_ready;
  assign pop       = out_fire & out_last;

  // Each input word needs at most one entry.
  assign in_ready  = (count_r != 2'd2) | pop;
  assign in_fire   = in_valid & in_ready;
  assign push      = in_fire & (step.cnt != 2'd0);

  assign out_char_out           = head_res.ch;
  assign out_is_end             = head_res.is_end;
  assign out_in_comment         = head_res.tags.comment;
  assign out_in_string          = head_res.tags.str;
  assign out_in_char_const      = head_res.tags.chr;
  assign out_open_comment_error = head_res.err;

  always_comb begin
    state_nxt = in_fire ? step.state : state_r;
    flags_nxt = in_fire ? step.flags : flags_r;
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CODE;
      flags_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      sub_r    <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      flags_r <= flags_nxt;
      count_r <= count_nxt;
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      if (out_fire) sub_r <= ~out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= '{two: (step.cnt == 2'd2), r0: step.r0, r1: step.r1};
    end
  end

  // The queue never holds more than two entries.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result queue overflow");

  // An end marker always returns the scanner to code with clear tags.
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_command == CMD_END) |=> (state_r == ST_CODE && flags_r == '0))
    else $error("scanner not back in code after end marker");

  // A byte belongs to at most one construct.
  a_tags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_in_comment, out_in_string, out_in_char_const}))
    else $error("more than one tag on a result word");

  // The open-comment flag appears only on end words, which carry no tags.
  a_err_only_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_open_comment_error) |-> out_is_end)
    else $error("open comment flag on a byte word");

  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_end) |->
      (out_last && out_char_out == CH_NUL && !out_in_comment && !out_in_string
       && !out_in_char_const))
    else $error("malformed end word");

endmodule : c_comment_literal_scanner
`default_nettype wire

// File: rtl/core/cls_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cls_step: scanner step logic
// Next state, next tags and up to two result words for one input word.
// ----------------------------------------------------------------------------
module cls_step (
  input  wire logic [cls_pkg::ST_W-1:0] scan_state,
  input  wire cls_pkg::flags_t          flags,
  input  wire logic                     command,
  input  wire logic [7:0]               char_in,
  output cls_pkg::step_t                step
);
  import cls_pkg::*;

  flags_t code_flags;
  logic [ST_W-1:0] code_state;
  logic code_emit;
  res_t code_res;
  res_t slash_res;
  res_t end_res;
  logic c_nz;

  // Scanning of a byte in code: shared by the code state and the lone slash.
  always_comb begin
    code_flags = '0;
    code_state = ST_CODE;
    code_emit  = (char_in != CH_NUL);
    if (char_in == CH_SLASH) begin
      code_state = ST_SLASH;
      code_emit  = 1'b0;
    end else if (char_in == CH_DQUOTE) begin
      code_flags.str = 1'b1;
      code_state     = ST_DQ;
    end else if (char_in == CH_SQUOTE) begin
      code_flags.chr = 1'b1;
      code_state     = ST_SQ;
    end
    code_res = '{ch: char_in, is_end: 1'b0, tags: code_flags, err: 1'b0};
  end

  assign c_nz      = (char_in != CH_NUL);
  assign slash_res = '{ch: CH_SLASH, is_end: 1'b0, tags: '0, err: 1'b0};
  assign end_res   = '{ch: CH_NUL, is_end: 1'b1, tags: '0,
                       err: (scan_state == ST_BLOCK) || (scan_state == ST_STAR)};

  always_comb begin
    step.state = scan_state;
    step.flags = flags;
    step.cnt   = {1'b0, c_nz};
    step.r0    = '{ch: char_in, is_end: 1'b0, tags: flags, err: 1'b0};
    step.r1    = '0;
    if (command == CMD_END) begin
      step.state = ST_CODE;
      step.flags = '0;
      if (scan_state == ST_SLASH) begin
        step.cnt = 2'd2;
        step.r0  = slash_res;
        step.r1  = end_res;
      end else begin
        step.cnt = 2'd1;
        step.r0  = end_res;
      end
    end else begin
      case (scan_state)
        ST_SLASH: begin
          if (char_in == CH_SLASH || char_in == CH_STAR) begin
            step.flags = '{comment: 1'b1, str: flags.str, chr: flags.chr};
            step.state = (char_in == CH_SLASH) ? ST_LINE : ST_BLOCK;
            step.cnt   = 2'd2;
            step.r0    = '{ch: CH_SLASH, is_end: 1'b0,
                           tags: '{comment: 1'b1, str: flags.str, chr: flags.chr},
                           err: 1'b0};
            step.r1    = '{ch: char_in, is_end: 1'b0,
                           tags: '{comment: 1'b1, str: flags.str, chr: flags.chr},
                           err: 1'b0};
          end else begin
            step.flags = code_flags;
            step.state = code_state;
            step.r0    = slash_res;
            step.r1    = code_res;
            step.cnt   = code_emit ? 2'd2 : 2'd1;
          end
        end
        ST_BLOCK: begin
          if (char_in == CH_STAR) step.state = ST_STAR;
        end
        ST_LINE: begin
          if (char_in == CH_NL) step.state = ST_CODE;
        end
        ST_STAR: begin
          if (char_in == CH_SLASH) begin
            step.state = ST_CODE;
          end else if (char_in != CH_STAR) begin
            step.state = ST_BLOCK;
          end
        end
        ST_DQ: begin
          if (char_in == CH_BSLASH) begin
            step.state = ST_DESC;
          end else if (char_in == CH_DQUOTE) begin
            step.state = ST_CODE;
          end
        end
        ST_SQ: begin
          if (char_in == CH_BSLASH) begin
            step.state = ST_SESC;
          end else if (char_in == CH_SQUOTE) begin
            step.state = ST_CODE;
          end
        end
        ST_DESC: step.state = ST_DQ;
        ST_SESC: step.state = ST_SQ;
        default: begin
          step.flags = code_flags;
          step.state = code_state;
          step.r0    = code_res;
          step.cnt   = {1'b0, code_emit};
        end
      endcase
    end
  end

endmodule : cls_step
`default_nettype wire
